FILE: src/bandwidth_constrained_dfs_path_macros.svh
// Assertion macros shared by the checker of the path search block
`ifndef BANDWIDTH_CONSTRAINED_DFS_PATH_MACROS_SVH
`define BANDWIDTH_CONSTRAINED_DFS_PATH_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define BCDFS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low
`define BCDFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/bcdfs_pkg.sv
// Shared types and constants of the bandwidth-constrained path search block
`timescale 1ns / 1ps

package bcdfs_pkg;

  // Fixed field widths
  localparam int NODE_W     = 4;
  localparam int FIELD_BW_W = 16;
  localparam int NCOUNT_W   = 5;
  localparam int CFG_AW     = 3;
  localparam int CFG_DW     = 32;

  // Parameter defaults
  localparam int MAX_NODES_DEF = 16;
  localparam int MAX_EDGES_DEF = 64;
  localparam int BW_BITS_DEF   = 16;

  localparam logic [NCOUNT_W-1:0] NODE_COUNT_RST = 5'd16;

  // Command codes
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_FIND = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_NODE    = 2'd0;
  localparam logic [1:0] ST_NO_PATH = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  // Register index (word address bit)
  localparam logic REG_NODE_COUNT = 1'b0;

  // Path query handed to the search sequencer
  typedef struct packed {
    logic [NODE_W-1:0]     src;
    logic [NODE_W-1:0]     dst;
    logic [FIELD_BW_W-1:0] min_bw;
  } query_t;

  // One result transaction
  typedef struct packed {
    logic [1:0]        status;
    logic [NODE_W-1:0] node;
    logic              last;
  } result_t;

endpackage

FILE: src/bcdfs_edge_mem.sv
// Edge table memory with fill count and sticky overflow flag
`timescale 1ns / 1ps

module bcdfs_edge_mem #(
  parameter int MAX_EDGES = bcdfs_pkg::MAX_EDGES_DEF,
  parameter int BW_W      = bcdfs_pkg::FIELD_BW_W,
  localparam int ETW      = $clog2(MAX_EDGES + 1),
  localparam int EAW      = $clog2(MAX_EDGES)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en_i,
  input  logic [bcdfs_pkg::NODE_W-1:0]  wr_from_i,
  input  logic [bcdfs_pkg::NODE_W-1:0]  wr_to_i,
  input  logic [BW_W-1:0]               wr_bw_i,
  input  logic [EAW-1:0]                rd_addr_i,
  output logic [bcdfs_pkg::NODE_W-1:0]  rd_from_o,
  output logic [bcdfs_pkg::NODE_W-1:0]  rd_to_o,
  output logic [BW_W-1:0]               rd_bw_o,
  output logic [ETW-1:0]                edge_total_o,
  output logic                          overflow_o
);

  localparam int EW = 2 * bcdfs_pkg::NODE_W + BW_W;

  logic [EW-1:0]  mem [MAX_EDGES];
  logic [EW-1:0]  rd_data_r;
  logic [ETW-1:0] total_r;
  logic           overflow_r;
  logic           full;

  assign full = (total_r >= ETW'(MAX_EDGES));

  // Fill count and sticky drop flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r    <= '0;
      overflow_r <= 1'b0;
    end else if (wr_en_i) begin
      if (full) begin
        overflow_r <= 1'b1;
      end else begin
        total_r <= ETW'(total_r + 1'b1);
      end
    end
  end

  // Append port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en_i && !full) begin
      mem[total_r[EAW-1:0]] <= {wr_from_i, wr_to_i, wr_bw_i};
    end
    rd_data_r <= mem[rd_addr_i];
  end

  assign rd_from_o    = rd_data_r[EW-1 -: bcdfs_pkg::NODE_W];
  assign rd_to_o      = rd_data_r[BW_W +: bcdfs_pkg::NODE_W];
  assign rd_bw_o      = rd_data_r[BW_W-1:0];
  assign edge_total_o = total_r;
  assign overflow_o   = overflow_r;

endmodule

FILE: src/bcdfs_search.sv
// Depth-first search sequencer: stack, visited marks and one edge check unit
`timescale 1ns / 1ps

module bcdfs_search #(
  parameter int MAX_NODES = bcdfs_pkg::MAX_NODES_DEF,
  parameter int MAX_EDGES = bcdfs_pkg::MAX_EDGES_DEF,
  parameter int BW_W      = bcdfs_pkg::FIELD_BW_W,
  localparam int ETW      = $clog2(MAX_EDGES + 1),
  localparam int EAW      = $clog2(MAX_EDGES)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start_i,
  input  bcdfs_pkg::query_t              query_i,
  input  logic [bcdfs_pkg::NCOUNT_W-1:0] n_i,
  input  logic [ETW-1:0]                 edge_total_i,
  output logic [EAW-1:0]                 rd_addr_o,
  input  logic [bcdfs_pkg::NODE_W-1:0]   rd_from_i,
  input  logic [bcdfs_pkg::NODE_W-1:0]   rd_to_i,
  input  logic [BW_W-1:0]                rd_bw_i,
  output logic                           busy_o,
  output logic                           res_valid_o,
  output bcdfs_pkg::result_t             res_o
);

  // Distinct node indices bound the stack
  localparam int NNODE = 1 << bcdfs_pkg::NODE_W;
  localparam int STK   = (MAX_NODES < NNODE) ? MAX_NODES : NNODE;
  localparam int SIW   = $clog2(STK);

  typedef enum logic [1:0] {S_IDLE, S_TOP, S_SCAN, S_EMIT} state_t;

  state_t                                state_r;
  logic [SIW-1:0]                        top_r;
  logic [SIW-1:0]                        emit_r;
  logic [bcdfs_pkg::NODE_W-1:0]          cur_node_r;
  logic [bcdfs_pkg::NODE_W-1:0]          dst_r;
  logic [bcdfs_pkg::FIELD_BW_W-1:0]      min_bw_r;
  logic [NNODE-1:0]                      visited_r;
  logic [ETW-1:0]                        scan_r;
  logic                                  pend_r;
  logic [ETW-1:0]                        pend_idx_r;
  logic                                  res_valid_r;
  bcdfs_pkg::result_t                    res_r;
  logic [bcdfs_pkg::NODE_W-1:0]          stack_node_r [STK];
  logic [ETW-1:0]                        stack_next_r [STK];

  logic [SIW-1:0]                        sel_idx;
  logic [bcdfs_pkg::NODE_W-1:0]          sel_node;
  logic                                  hit;
  logic                                  more;
  logic                                  range_err;

  // Single stack read port: emit index while emitting, top otherwise
  assign sel_idx  = (state_r == S_EMIT) ? emit_r : top_r;
  assign sel_node = stack_node_r[sel_idx];

  // Shared edge check unit on the registered table entry
  assign hit = pend_r && (rd_from_i == cur_node_r) &&
               ({1'b0, rd_to_i} < n_i) && !visited_r[rd_to_i] &&
               (bcdfs_pkg::FIELD_BW_W'(rd_bw_i) >= min_bw_r);
  assign more = (scan_r < edge_total_i);

  assign range_err = ({1'b0, query_i.src} >= n_i) || ({1'b0, query_i.dst} >= n_i);

  assign rd_addr_o = scan_r[EAW-1:0];

  // Sequencer state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      top_r       <= '0;
      visited_r   <= '0;
      pend_r      <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start_i) begin
            dst_r    <= query_i.dst;
            min_bw_r <= query_i.min_bw;
            if (range_err) begin
              res_r       <= '{status: bcdfs_pkg::ST_RANGE, node: '0, last: 1'b1};
              res_valid_r <= 1'b1;
            end else begin
              stack_node_r[0] <= query_i.src;
              stack_next_r[0] <= '0;
              top_r           <= '0;
              visited_r       <= NNODE'(1) << query_i.src;
              state_r         <= S_TOP;
            end
          end
        end
        // Load the top entry, stop if it is the destination
        S_TOP: begin
          cur_node_r <= sel_node;
          scan_r     <= stack_next_r[top_r];
          if (sel_node == dst_r) begin
            emit_r  <= '0;
            state_r <= S_EMIT;
          end else begin
            state_r <= S_SCAN;
          end
        end
        // One table read issued and one entry checked per cycle
        S_SCAN: begin
          if (hit) begin
            stack_next_r[top_r] <= ETW'(pend_idx_r + 1'b1);
            stack_node_r[SIW'(top_r + 1'b1)] <= rd_to_i;
            stack_next_r[SIW'(top_r + 1'b1)] <= '0;
            top_r     <= SIW'(top_r + 1'b1);
            visited_r <= visited_r | (NNODE'(1) << rd_to_i);
            state_r   <= S_TOP;
          end else if (more) begin
            pend_r     <= 1'b1;
            pend_idx_r <= scan_r;
            scan_r     <= ETW'(scan_r + 1'b1);
          end else if (!pend_r) begin
            // Edges exhausted: backtrack
            if (top_r == '0) begin
              res_r       <= '{status: bcdfs_pkg::ST_NO_PATH, node: '0, last: 1'b1};
              res_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end else begin
              top_r   <= SIW'(top_r - 1'b1);
              state_r <= S_TOP;
            end
          end
        end
        // Stream the path, source first
        S_EMIT: begin
          res_r       <= '{status: bcdfs_pkg::ST_NODE, node: sel_node,
                           last: (emit_r == top_r)};
          res_valid_r <= 1'b1;
          if (emit_r == top_r) begin
            state_r <= S_IDLE;
          end else begin
            emit_r <= SIW'(emit_r + 1'b1);
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy_o      = (state_r != S_IDLE);
  assign res_valid_o = res_valid_r;
  assign res_o       = res_r;

endmodule

FILE: src/bandwidth_constrained_dfs_path.sv
// Top level: config register, command decode, edge table and search sequencer
// Add-edge: accepted while idle, busy stays low, no result. Out-of-range query: one
//   status result in the cycle after acceptance, busy stays low.
// Search: for each stack entry, load it, then check table entries in order from where it
//   last left off; a hit pushes the new node, running out of entries pops back one level.
// Path: one result per node on back-to-back cycles; busy is low with the last one, so the
//   next transaction can be taken in that cycle. Reset (rst_n low, synchronous) clears
//   edge count, drop flag and search state, sets node_count to 16; table is not cleared.
`timescale 1ns / 1ps

module bandwidth_constrained_dfs_path #(
  parameter int MAX_NODES = bcdfs_pkg::MAX_NODES_DEF,
  parameter int MAX_EDGES = bcdfs_pkg::MAX_EDGES_DEF,
  parameter int BW_BITS   = bcdfs_pkg::BW_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bcdfs_pkg::CFG_AW-1:0]     paddr,
  input  logic [bcdfs_pkg::CFG_DW-1:0]     pwdata,
  output logic [bcdfs_pkg::CFG_DW-1:0]     prdata,
  output logic                             pready,
  // command channel
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_cmd,
  input  logic [bcdfs_pkg::NODE_W-1:0]     in_edge_from,
  input  logic [bcdfs_pkg::NODE_W-1:0]     in_edge_to,
  input  logic [bcdfs_pkg::FIELD_BW_W-1:0] in_edge_bandwidth,
  input  logic [bcdfs_pkg::NODE_W-1:0]     in_source_node,
  input  logic [bcdfs_pkg::NODE_W-1:0]     in_dest_node,
  input  logic [bcdfs_pkg::FIELD_BW_W-1:0] in_min_bandwidth,
  // result channel
  output logic                             out_valid,
  output logic [1:0]                       out_status,
  output logic [bcdfs_pkg::NODE_W-1:0]     out_path_node,
  output logic                             out_last,
  output logic                             out_edges_dropped
);

  localparam int BW_W = (BW_BITS < bcdfs_pkg::FIELD_BW_W) ? BW_BITS : bcdfs_pkg::FIELD_BW_W;
  localparam int ETW  = $clog2(MAX_EDGES + 1);
  localparam int EAW  = $clog2(MAX_EDGES);
  localparam int NCW  = bcdfs_pkg::NCOUNT_W;

  logic [NCW-1:0]               node_count_r;
  logic [NCW-1:0]               n_eff;
  logic                         cfg_wr;
  logic                         accept;
  logic                         add_en;
  logic                         find_en;
  bcdfs_pkg::query_t            query;
  bcdfs_pkg::result_t           res;
  logic                         res_valid;
  logic [EAW-1:0]               rd_addr;
  logic [bcdfs_pkg::NODE_W-1:0] rd_from;
  logic [bcdfs_pkg::NODE_W-1:0] rd_to;
  logic [BW_W-1:0]              rd_bw;
  logic [ETW-1:0]               edge_total;
  logic                         overflow;

  // Register write at the access phase
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= bcdfs_pkg::NODE_COUNT_RST;
    end else if (cfg_wr && (paddr[2] == bcdfs_pkg::REG_NODE_COUNT)) begin
      node_count_r <= pwdata[NCW-1:0];
    end
  end

  // Register read decode
  always_comb begin
    unique case (paddr[2])
      bcdfs_pkg::REG_NODE_COUNT: prdata = bcdfs_pkg::CFG_DW'(node_count_r);
      default:                   prdata = '0;
    endcase
  end

  // Node count clamped to the supported node range
  assign n_eff = (7'(node_count_r) > 7'(MAX_NODES)) ? NCW'(MAX_NODES) : node_count_r;

  // Command decode
  assign accept  = start && !busy;
  assign add_en  = accept && (in_cmd == bcdfs_pkg::CMD_ADD);
  assign find_en = accept && (in_cmd == bcdfs_pkg::CMD_FIND);

  assign query = '{src:    in_source_node,
                   dst:    in_dest_node,
                   min_bw: bcdfs_pkg::FIELD_BW_W'(in_min_bandwidth[BW_W-1:0])};

  bcdfs_edge_mem #(
    .MAX_EDGES (MAX_EDGES),
    .BW_W      (BW_W)
  ) u_edge_mem (
    .clk          (clk),
    .rst_n        (rst_n),
    .wr_en_i      (add_en),
    .wr_from_i    (in_edge_from),
    .wr_to_i      (in_edge_to),
    .wr_bw_i      (in_edge_bandwidth[BW_W-1:0]),
    .rd_addr_i    (rd_addr),
    .rd_from_o    (rd_from),
    .rd_to_o      (rd_to),
    .rd_bw_o      (rd_bw),
    .edge_total_o (edge_total),
    .overflow_o   (overflow)
  );

  bcdfs_search #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES),
    .BW_W      (BW_W)
  ) u_search (
    .clk          (clk),
    .rst_n        (rst_n),
    .start_i      (find_en),
    .query_i      (query),
    .n_i          (n_eff),
    .edge_total_i (edge_total),
    .rd_addr_o    (rd_addr),
    .rd_from_i    (rd_from),
    .rd_to_i      (rd_to),
    .rd_bw_i      (rd_bw),
    .busy_o       (busy),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  // Result transaction
  assign out_valid         = res_valid;
  assign out_status        = res.status;
  assign out_path_node     = res.node;
  assign out_last          = res.last;
  assign out_edges_dropped = overflow;

endmodule

FILE: src/bcdfs_checker.sv
// Port-level checker of the path search block and its bind
`timescale 1ns / 1ps
`include "bandwidth_constrained_dfs_path_macros.svh"

module bcdfs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       in_cmd,
  input logic       out_valid,
  input logic [1:0] out_status,
  input logic       out_last,
  input logic       out_edges_dropped
);

  // A status transaction always closes its query
  `BCDFS_ASSERT_SAME(a_status_last, clk, rst_n, out_valid && (out_status != bcdfs_pkg::ST_NODE), out_last, "status result without last")

  // An accepted query is answered at once or the block goes busy
  `BCDFS_ASSERT_NEXT(a_query_busy, clk, rst_n, start && !busy && (in_cmd == bcdfs_pkg::CMD_FIND), busy || out_valid, "query neither answered nor started")

  // Path nodes come back to back until the last one
  `BCDFS_ASSERT_NEXT(a_path_burst, clk, rst_n, out_valid && !out_last, out_valid, "gap inside a path burst")

  // The block is free again when the final transaction shows
  `BCDFS_ASSERT_SAME(a_last_idle, clk, rst_n, out_valid && out_last, !busy, "busy with the final result")

  // Drop flag is sticky
  `BCDFS_ASSERT_SAME(a_drop_sticky, clk, rst_n, $past(rst_n) && $past(out_edges_dropped), out_edges_dropped, "drop flag cleared")

endmodule

bind bandwidth_constrained_dfs_path bcdfs_checker u_bcdfs_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .in_cmd            (in_cmd),
  .out_valid         (out_valid),
  .out_status        (out_status),
  .out_last          (out_last),
  .out_edges_dropped (out_edges_dropped)
);

FILE: dv/tb_bandwidth_constrained_dfs_path.sv
// Testbench for the path search block: directed and random traffic against a predictor
`timescale 1ns / 1ps

module tb_bandwidth_constrained_dfs_path;

  localparam int EDGE_SLOTS  = bcdfs_pkg::MAX_EDGES_DEF;
  localparam int NODE_SLOTS  = bcdfs_pkg::MAX_NODES_DEF;
  localparam int STALL_LIMIT = 20000;
  localparam logic [bcdfs_pkg::CFG_AW-1:0] NODE_COUNT_ADDR = {bcdfs_pkg::REG_NODE_COUNT, 2'b00};

  // One command transaction as seen on the input ports
  typedef struct {
    logic                             cmd;
    logic [bcdfs_pkg::NODE_W-1:0]     from_node;
    logic [bcdfs_pkg::NODE_W-1:0]     to_node;
    logic [bcdfs_pkg::FIELD_BW_W-1:0] bw;
    logic [bcdfs_pkg::NODE_W-1:0]     src;
    logic [bcdfs_pkg::NODE_W-1:0]     dst;
    logic [bcdfs_pkg::FIELD_BW_W-1:0] min_bw;
  } cmd_item_t;

  // One expected result transaction
  typedef struct packed {
    logic [1:0]                   status;
    logic [bcdfs_pkg::NODE_W-1:0] node;
    logic                         last;
    logic                         dropped;
  } path_res_t;

  logic                             clk;
  logic                             rst_n;
  logic                             psel;
  logic                             penable;
  logic                             pwrite;
  logic [bcdfs_pkg::CFG_AW-1:0]     paddr;
  logic [bcdfs_pkg::CFG_DW-1:0]     pwdata;
  logic [bcdfs_pkg::CFG_DW-1:0]     prdata;
  logic                             pready;
  logic                             start;
  logic                             busy;
  logic                             in_cmd;
  logic [bcdfs_pkg::NODE_W-1:0]     in_edge_from;
  logic [bcdfs_pkg::NODE_W-1:0]     in_edge_to;
  logic [bcdfs_pkg::FIELD_BW_W-1:0] in_edge_bandwidth;
  logic [bcdfs_pkg::NODE_W-1:0]     in_source_node;
  logic [bcdfs_pkg::NODE_W-1:0]     in_dest_node;
  logic [bcdfs_pkg::FIELD_BW_W-1:0] in_min_bandwidth;
  logic                             out_valid;
  logic [1:0]                       out_status;
  logic [bcdfs_pkg::NODE_W-1:0]     out_path_node;
  logic                             out_last;
  logic                             out_edges_dropped;

  // Predictor state: edge table, drop flag and node count register
  logic [bcdfs_pkg::NODE_W-1:0]     tab_from [EDGE_SLOTS];
  logic [bcdfs_pkg::NODE_W-1:0]     tab_to   [EDGE_SLOTS];
  logic [bcdfs_pkg::FIELD_BW_W-1:0] tab_bw   [EDGE_SLOTS];
  int                               edge_cnt = 0;
  logic                             drop_flag = 1'b0;
  logic [bcdfs_pkg::NCOUNT_W-1:0]   node_count_q = bcdfs_pkg::NODE_COUNT_RST;
  int                               route_buf [NODE_SLOTS];

  path_res_t route_q [$];
  bit        gaps_on = 1'b1;
  int        err_cnt = 0;
  int        item_cnt = 0;
  int        res_cnt = 0;
  int        found_cnt = 0;
  int        nopath_cnt = 0;
  int        range_cnt = 0;
  int        dropped_cnt = 0;
  int        stall_cnt = 0;

  bandwidth_constrained_dfs_path i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .start             (start),
    .busy              (busy),
    .in_cmd            (in_cmd),
    .in_edge_from      (in_edge_from),
    .in_edge_to        (in_edge_to),
    .in_edge_bandwidth (in_edge_bandwidth),
    .in_source_node    (in_source_node),
    .in_dest_node      (in_dest_node),
    .in_min_bandwidth  (in_min_bandwidth),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_path_node     (out_path_node),
    .out_last          (out_last),
    .out_edges_dropped (out_edges_dropped)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Nodes in use, clamped to the table's node limit
  function automatic int eff_nodes();
    return (node_count_q > NODE_SLOTS) ? NODE_SLOTS : int'(node_count_q);
  endfunction

  // Append one expectation at the tail of the result queue
  function automatic void queue_result(input logic [1:0] status,
                                       input logic [bcdfs_pkg::NODE_W-1:0] node,
                                       input logic last);
    path_res_t r;
    r.status  = status;
    r.node    = node;
    r.last    = last;
    r.dropped = drop_flag;
    route_q.insert(route_q.size(), r);
  endfunction

  // Depth-first search; leaves the path in route_buf, returns its length or 0
  function automatic int search_path(input int src, input int dst,
                                     input logic [bcdfs_pkg::FIELD_BW_W-1:0] min_bw,
                                     input int n);
    int                    next_edge [NODE_SLOTS];
    logic [NODE_SLOTS-1:0] seen;
    int                    depth;
    int                    top;
    int                    i;
    bit                    moved;
    seen = '0;
    route_buf[0] = src;
    next_edge[0] = 0;
    seen[src] = 1'b1;
    depth = 1;
    while (depth > 0) begin
      top = depth - 1;
      if (route_buf[top] == dst) return depth;
      moved = 1'b0;
      for (i = next_edge[top]; i < edge_cnt && !moved; i++) begin
        if (tab_from[i] == route_buf[top] && tab_to[i] < n && !seen[tab_to[i]] &&
            tab_bw[i] >= min_bw) begin
          next_edge[top] = i + 1;
          route_buf[depth] = int'(tab_to[i]);
          next_edge[depth] = 0;
          seen[tab_to[i]] = 1'b1;
          depth++;
          moved = 1'b1;
        end
      end
      if (!moved) depth--;
    end
    return 0;
  endfunction

  // Update the predictor for one accepted transaction and queue its results
  function automatic void apply_item(input cmd_item_t it);
    int n;
    int len;
    int k;
    n = eff_nodes();
    if (it.cmd == bcdfs_pkg::CMD_ADD) begin
      if (edge_cnt < EDGE_SLOTS) begin
        tab_from[edge_cnt] = it.from_node;
        tab_to[edge_cnt]   = it.to_node;
        tab_bw[edge_cnt]   = it.bw;
        edge_cnt++;
      end else begin
        drop_flag = 1'b1;
        dropped_cnt++;
      end
    end else if (it.src >= n || it.dst >= n) begin
      queue_result(bcdfs_pkg::ST_RANGE, '0, 1'b1);
      range_cnt++;
    end else begin
      len = search_path(int'(it.src), int'(it.dst), it.min_bw, n);
      if (len == 0) begin
        queue_result(bcdfs_pkg::ST_NO_PATH, '0, 1'b1);
        nopath_cnt++;
      end else begin
        for (k = 0; k < len; k++)
          queue_result(bcdfs_pkg::ST_NODE, route_buf[k][bcdfs_pkg::NODE_W-1:0], k == len - 1);
        found_cnt++;
      end
    end
  endfunction

  // Drive one transaction from a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input cmd_item_t it);
    while (gaps_on && $urandom_range(0, 99) < 26) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start             <= 1'b1;
    in_cmd            <= it.cmd;
    in_edge_from      <= it.from_node;
    in_edge_to        <= it.to_node;
    in_edge_bandwidth <= it.bw;
    in_source_node    <= it.src;
    in_dest_node      <= it.dst;
    in_min_bandwidth  <= it.min_bw;
    do @(posedge clk); while (busy);
    apply_item(it);
    item_cnt++;
    @(negedge clk);
  endtask

  task automatic send_add(input int from_node, input int to_node, input int bw);
    cmd_item_t it;
    it.cmd       = bcdfs_pkg::CMD_ADD;
    it.from_node = bcdfs_pkg::NODE_W'(from_node);
    it.to_node   = bcdfs_pkg::NODE_W'(to_node);
    it.bw        = bcdfs_pkg::FIELD_BW_W'(bw);
    it.src       = bcdfs_pkg::NODE_W'($urandom);
    it.dst       = bcdfs_pkg::NODE_W'($urandom);
    it.min_bw    = bcdfs_pkg::FIELD_BW_W'($urandom);
    send_item(it);
  endtask

  task automatic send_query(input int src, input int dst, input int min_bw);
    cmd_item_t it;
    it.cmd       = bcdfs_pkg::CMD_FIND;
    it.from_node = bcdfs_pkg::NODE_W'($urandom);
    it.to_node   = bcdfs_pkg::NODE_W'($urandom);
    it.bw        = bcdfs_pkg::FIELD_BW_W'($urandom);
    it.src       = bcdfs_pkg::NODE_W'(src);
    it.dst       = bcdfs_pkg::NODE_W'(dst);
    it.min_bw    = bcdfs_pkg::FIELD_BW_W'(min_bw);
    send_item(it);
  endtask

  // Hold off until every expected result has arrived and the block is idle
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (route_q.size() != 0 || busy);
    repeat (4) @(negedge clk);
  endtask

  // Write node_count over the APB port, then read it back
  task automatic write_node_count(input logic [bcdfs_pkg::NCOUNT_W-1:0] value);
    logic [bcdfs_pkg::CFG_DW-1:0] word;
    word = $urandom;
    word[bcdfs_pkg::NCOUNT_W-1:0] = value;
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= NODE_COUNT_ADDR;
    pwdata  <= word;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    node_count_q = value;
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[bcdfs_pkg::NCOUNT_W-1:0] !== value) begin
      err_cnt++;
      $display("%0t: node_count read back expected %0d actual %0d", $time, value,
               prdata[bcdfs_pkg::NCOUNT_W-1:0]);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Mostly nodes in use, now and then any node
  function automatic int pick_node(input int n);
    return ($urandom_range(0, 99) < 85) ? $urandom_range(0, n - 1) : $urandom_range(0, 15);
  endfunction

  // Low thresholds keep paths feasible; full range still reached
  function automatic int pick_min_bw();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return 0;
    if (roll < 70) return $urandom_range(0, 16'h3fff);
    return $urandom_range(0, 16'hffff);
  endfunction

  task automatic send_random(input int add_pct);
    int n;
    n = eff_nodes();
    if ($urandom_range(0, 99) < add_pct)
      send_add(pick_node(n), pick_node(n), $urandom_range(0, 16'hffff));
    else
      send_query(pick_node(n), pick_node(n), pick_min_bw());
  endtask

  // Queries on an empty table
  task automatic test_empty_table();
    send_query(0, 0, 0);
    send_query(0, 15, 0);
    send_query(15, 15, 16'hffff);
  endtask

  // Small graph with a dead end, a cycle and a self loop; thresholds at the edge values
  task automatic test_directed_paths();
    send_add(0, 1, 16'hffff);
    send_add(1, 2, 0);
    send_add(0, 2, 100);
    send_add(2, 15, 50000);
    send_add(15, 0, 10);
    send_add(2, 2, 1);
    send_add(5, 6, 7);
    send_query(0, 15, 0);
    send_query(0, 15, 100);
    send_query(0, 15, 101);
    send_query(0, 15, 16'hffff);
    send_query(15, 2, 10);
    send_query(15, 2, 11);
    send_query(5, 6, 7);
    send_query(6, 5, 0);
  endtask

  // Node count at its extremes, including zero and beyond the node limit
  task automatic test_node_count_limits();
    write_node_count(5'd3);
    send_query(0, 2, 0);
    send_query(0, 3, 0);
    write_node_count(5'd0);
    send_query(0, 0, 0);
    write_node_count(5'd31);
    send_query(15, 2, 0);
    write_node_count(5'd1);
    send_query(0, 0, 0);
    send_query(0, 1, 0);
  endtask

  task automatic test_random_traffic(input int count,
                                     input logic [bcdfs_pkg::NCOUNT_W-1:0] nodes,
                                     input bit gaps);
    int i;
    write_node_count(nodes);
    gaps_on = gaps;
    for (i = 0; i < count; i++) send_random(45);
    gaps_on = 1'b1;
  endtask

  // Fill the edge table, overflow it, then query with the drop flag set
  task automatic test_table_overflow();
    int i;
    write_node_count(5'd16);
    while (edge_cnt < EDGE_SLOTS)
      send_add($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 16'hffff));
    for (i = 0; i < 3; i++)
      send_add($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 16'hffff));
    for (i = 0; i < 8; i++) send_random(20);
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      err_cnt++;
      $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin : check_results
    path_res_t exp_r;
    if (rst_n && out_valid) begin
      res_cnt++;
      if (route_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result expected none actual status %0d node %0d last %b",
                 $time, out_status, out_path_node, out_last);
      end else begin
        exp_r = route_q.pop_front();
        check_field("status", 16'(exp_r.status), 16'(out_status));
        check_field("path_node", 16'(exp_r.node), 16'(out_path_node));
        check_field("last", 16'(exp_r.last), 16'(out_last));
        check_field("edges_dropped", 16'(exp_r.dropped), 16'(out_edges_dropped));
      end
    end
  end

  // Watchdog: cycles with no transaction on any port
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (psel && penable)) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst_n             = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    start             = 1'b0;
    in_cmd            = bcdfs_pkg::CMD_ADD;
    in_edge_from      = '0;
    in_edge_to        = '0;
    in_edge_bandwidth = '0;
    in_source_node    = '0;
    in_dest_node      = '0;
    in_min_bandwidth  = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_directed_paths();
    test_node_count_limits();
    test_random_traffic(15, 5'd16, 1'b1);
    test_random_traffic(20, 5'($urandom_range(2, 15)), 1'b0);
    test_random_traffic(5, 5'd31, 1'b1);
    test_table_overflow();

    wait_idle();
    repeat (20) @(posedge clk);
    $display("Sent %0d transactions: %0d edges stored, %0d dropped,", item_cnt, edge_cnt,
             dropped_cnt);
    $display("%0d paths found, %0d unreachable, %0d out of range; %0d results, %0d mismatches",
             found_cnt, nopath_cnt, range_cnt, res_cnt, err_cnt);
    if (err_cnt == 0 && route_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/bcdfs_pkg.sv
src/bcdfs_edge_mem.sv
src/bcdfs_search.sv
src/bandwidth_constrained_dfs_path.sv
src/bcdfs_checker.sv
dv/tb_bandwidth_constrained_dfs_path.sv
